### rtl/wjts_pkg.sv
// ----------------------------------------------------------------------------
// wjts_pkg
// Types, constants and helpers of the windowed joint and tool speed block.
// ----------------------------------------------------------------------------
package wjts_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int JOINTS        = 6;
    localparam int AXES          = 3;
    localparam int ANGLE_W       = 24;
    localparam int POS_W         = 32;
    localparam int TIME_W        = 32;
    localparam int SPEED_W       = 24;
    localparam int CFG_W         = 20;
    localparam int CFG_IDX_W     = 2;
    localparam int ROW_W         = JOINTS * ANGLE_W + AXES * POS_W;
    localparam int TOOL_BASE     = JOINTS * ANGLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] WINDOW_RESET = 20'd120000;
    localparam logic [CFG_W-1:0] MIN_RESET    = 20'd40000;

    localparam logic signed [34:0] PI_Q24     = 35'sd52707179;
    localparam logic signed [34:0] TWO_PI_Q24 = 35'sd105414357;
    localparam logic [25:0]        DEG_SCALE  = 26'd57295780;
    localparam logic [13:0]        TOOL_SCALE = 14'd15625;
    localparam logic [2:0]         WRAP_LAST  = 3'd5;
    localparam logic [5:0]         ROOT_TOP   = 6'd40;

    typedef struct packed {
        logic                      trace_start;
        logic [TIME_W-1:0]         sample_time_us;
        logic signed [ANGLE_W-1:0] joint_angle_0;
        logic signed [ANGLE_W-1:0] joint_angle_1;
        logic signed [ANGLE_W-1:0] joint_angle_2;
        logic signed [ANGLE_W-1:0] joint_angle_3;
        logic signed [ANGLE_W-1:0] joint_angle_4;
        logic signed [ANGLE_W-1:0] joint_angle_5;
        logic signed [POS_W-1:0]   tool_x;
        logic signed [POS_W-1:0]   tool_y;
        logic signed [POS_W-1:0]   tool_z;
    } t_sample;

    typedef struct packed {
        logic [TIME_W-1:0]         result_time_us;
        logic signed [SPEED_W-1:0] joint_speed_0;
        logic signed [SPEED_W-1:0] joint_speed_1;
        logic signed [SPEED_W-1:0] joint_speed_2;
        logic signed [SPEED_W-1:0] joint_speed_3;
        logic signed [SPEED_W-1:0] joint_speed_4;
        logic signed [SPEED_W-1:0] joint_speed_5;
        logic [SPEED_W-1:0]        tool_speed;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE, S_WRD, S_WCHK, S_FRD, S_FCHK, S_JINIT, S_JWRAP, S_JFIX,
        S_JMUL, S_TSQ, S_TSQRT, S_TMUL, S_DINIT, S_DITER, S_DSTORE, S_DONE
    } t_state;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        if (s == SLOT_W'(HISTORY_DEPTH - 1)) begin
            return '0;
        end
        return s + SLOT_W'(1);
    endfunction

    function automatic logic signed [34:0] wrap_step(input logic [2:0] c);
        return TWO_PI_Q24 <<< (WRAP_LAST - c);
    endfunction

endpackage

### rtl/wjts_if.sv
// ----------------------------------------------------------------------------
// wjts channel interfaces
// Sample, result and configuration write channels with valid and ready.
// ----------------------------------------------------------------------------
interface wjts_sample_if;
    import wjts_pkg::*;
    logic    valid;
    logic    ready;
    t_sample payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wjts_result_if;
    import wjts_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wjts_cfg_if;
    import wjts_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/wjts_ram.sv
// ----------------------------------------------------------------------------
// wjts_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wjts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/windowed_joint_and_tool_speed.sv
// ----------------------------------------------------------------------------
// windowed_joint_and_tool_speed
// Windowed finite difference speed of six joints and the tool position.
//
//  channel   | dir | beat
//  i_sample  | in  | one timestamped sample (joints, tool position)
//  o_result  | out | one speed result, zero or one per sample
//  i_cfg     | in  | register write (window, minimum interval)
//
// One sample at a time. A sample with a result walks the window in R
// reference steps (one time RAM read each) and then runs seven 24-step
// divides, each skipped when it saturates, and a 41-step square root; a
// sample without a result ends at or before the interval check. Reset is
// synchronous and needs no clearing pass. A waiting result holds while the
// next sample is taken; the sequencer stalls at its end until the output
// register is free.
// ----------------------------------------------------------------------------
module windowed_joint_and_tool_speed (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wjts_sample_if.sink          i_sample,
    wjts_result_if.source        o_result,
    wjts_cfg_if.sink             i_cfg
);
    import wjts_pkg::*;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count;
    logic [SLOT_W-1:0]          r_slot, r_ref;
    logic [CFG_W-1:0]           r_window, r_min;
    logic                       r_ov;
    t_result                    r_out;

    t_sample                    r_cur;
    logic [TIME_W-1:0]          r_dt;
    logic [ROW_W-1:0]           r_row;
    logic [2:0]                 r_j;
    logic                       r_tool;
    logic signed [34:0]         r_v;
    logic [2:0]                 r_step;
    logic                       r_neg, r_wneg;
    logic [25:0]                r_mag;
    logic [48:0]                r_x;
    logic [SPEED_W-1:0]         r_q;
    logic [31:0]                r_rem;
    logic [4:0]                 r_bit;
    logic [65:0]                r_sum;
    logic [1:0]                 r_axis;
    logic [40:0]                r_root;
    logic [44:0]                r_srem;
    logic [5:0]                 r_sk;
    logic [SPEED_W-1:0]         r_speed [JOINTS];

    logic                       accept, first;
    logic [SLOT_W-1:0]          acc_slot, acc_ref;
    logic [CNT_W-1:0]           acc_count;
    logic [SLOT_W-1:0]          ref_next;
    logic [SLOT_W-1:0]          time_raddr;
    logic [TIME_W-1:0]          time_rdata;
    logic [ROW_W-1:0]           row_rdata, row_wdata;
    logic [TIME_W-1:0]          walk_diff, fin_dt;
    logic signed [ANGLE_W-1:0]  cur_ang [JOINTS];
    logic signed [POS_W-1:0]    cur_pos [AXES];

    // ------------------------------------------------------------------
    assign cur_ang[0] = r_cur.joint_angle_0;
    assign cur_ang[1] = r_cur.joint_angle_1;
    assign cur_ang[2] = r_cur.joint_angle_2;
    assign cur_ang[3] = r_cur.joint_angle_3;
    assign cur_ang[4] = r_cur.joint_angle_4;
    assign cur_ang[5] = r_cur.joint_angle_5;
    assign cur_pos[0] = r_cur.tool_x;
    assign cur_pos[1] = r_cur.tool_y;
    assign cur_pos[2] = r_cur.tool_z;

    assign row_wdata = {i_sample.payload.tool_z, i_sample.payload.tool_y,
                        i_sample.payload.tool_x,
                        i_sample.payload.joint_angle_5, i_sample.payload.joint_angle_4,
                        i_sample.payload.joint_angle_3, i_sample.payload.joint_angle_2,
                        i_sample.payload.joint_angle_1, i_sample.payload.joint_angle_0};

    assign accept    = i_sample.valid && i_sample.ready;
    assign first     = i_sample.payload.trace_start || (r_count == '0);
    assign ref_next  = next_slot(r_ref);
    assign walk_diff = r_cur.sample_time_us - time_rdata;
    assign fin_dt    = r_cur.sample_time_us - time_rdata;

    always_comb begin
        acc_slot  = next_slot(r_slot);
        acc_ref   = r_ref;
        acc_count = r_count;
        if (first) begin
            acc_slot  = '0;
            acc_ref   = '0;
            acc_count = CNT_W'(1);
        end else if (r_count >= CNT_W'(HISTORY_DEPTH)) begin
            acc_count = CNT_W'(HISTORY_DEPTH);
            if (r_ref == acc_slot) begin
                acc_ref = next_slot(acc_slot);
            end
        end else begin
            acc_count = r_count + CNT_W'(1);
        end
    end

    wjts_ram #(.WIDTH(TIME_W), .DEPTH(HISTORY_DEPTH)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (acc_slot),
        .i_wdata (i_sample.payload.sample_time_us),
        .i_raddr (time_raddr),
        .o_rdata (time_rdata)
    );

    wjts_ram #(.WIDTH(ROW_W), .DEPTH(HISTORY_DEPTH)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (acc_slot),
        .i_wdata (row_wdata),
        .i_raddr (r_ref),
        .o_rdata (row_rdata)
    );

    // ------------------------------------------------------------------
    // outputs
    always_comb begin
        i_sample.ready   = (r_state == S_IDLE);
        i_cfg.ready      = 1'b1;
        o_result.valid   = r_ov;
        o_result.payload = r_out;
        time_raddr       = (r_state == S_WRD) ? ref_next : r_ref;
    end

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (acc_count < CNT_W'(2)) ? S_IDLE : S_WRD;
                end
            end
            S_WRD:   n_state = S_WCHK;
            S_WCHK: begin
                if (ref_next != r_slot && walk_diff >= TIME_W'(r_window)) begin
                    n_state = S_WRD;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_FRD:   n_state = S_FCHK;
            S_FCHK: begin
                if (fin_dt == '0 || fin_dt < TIME_W'(r_min)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_JINIT;
                end
            end
            S_JINIT: n_state = S_JWRAP;
            S_JWRAP: n_state = (r_step == WRAP_LAST) ? S_JFIX : S_JWRAP;
            S_JFIX:  n_state = S_JMUL;
            S_JMUL:  n_state = S_DINIT;
            S_TSQ:   n_state = (r_axis == 2'(AXES - 1)) ? S_TSQRT : S_TSQ;
            S_TSQRT: n_state = (r_sk == '0) ? S_TMUL : S_TSQRT;
            S_TMUL:  n_state = S_DINIT;
            S_DINIT: n_state = ({7'b0, r_x[48:24]} >= r_dt) ? S_DSTORE : S_DITER;
            S_DITER: n_state = (r_bit == '0) ? S_DSTORE : S_DITER;
            S_DSTORE: begin
                if (r_tool) begin
                    n_state = S_DONE;
                end else if (r_j == 3'(JOINTS - 1)) begin
                    n_state = S_TSQ;
                end else begin
                    n_state = S_JINIT;
                end
            end
            S_DONE:  n_state = r_ov ? S_DONE : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_slot   <= '0;
            r_ref    <= '0;
            r_ov     <= 1'b0;
            r_window <= WINDOW_RESET;
            r_min    <= MIN_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_WINDOW) begin
                    r_window <= i_cfg.data;
                end else if (i_cfg.index == REG_MIN_INTERVAL) begin
                    r_min <= i_cfg.data;
                end
            end
            if (accept) begin
                r_count <= acc_count;
                r_slot  <= acc_slot;
                r_ref   <= acc_ref;
            end
            if (r_state == S_WCHK && n_state == S_WRD) begin
                r_ref <= ref_next;
            end
            if (o_result.valid && o_result.ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == S_DONE && !r_ov) begin
                r_ov <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath
    always_ff @(posedge i_clk) begin
        logic signed [24:0] d_ang;
        logic signed [34:0] w, t, v, ws;
        logic [52:0]        prod;
        logic [32:0]        dtrial;
        logic signed [32:0] d_pos;
        logic [32:0]        m;
        logic [81:0]        vq;
        logic [1:0]         pair;
        logic [44:0]        srem, trial;
        logic [55:0]        tn;
        logic [SPEED_W-1:0] qs;
        d_ang  = '0;
        w      = '0;
        t      = '0;
        v      = '0;
        ws     = '0;
        prod   = '0;
        dtrial = '0;
        d_pos  = '0;
        m      = '0;
        vq     = '0;
        pair   = '0;
        srem   = '0;
        trial  = '0;
        tn     = '0;
        qs     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_cur <= i_sample.payload;
                end
            end
            S_FCHK: begin
                r_dt   <= fin_dt;
                r_row  <= row_rdata;
                r_j    <= '0;
                r_tool <= 1'b0;
            end
            S_JINIT: begin
                d_ang  = 25'(cur_ang[r_j]) - 25'(signed'(r_row[r_j*ANGLE_W +: ANGLE_W]));
                w      = 35'(d_ang) <<< 8;
                r_neg  <= w < 0;
                r_v    <= (w < 0) ? -w : w;
                r_step <= '0;
            end
            S_JWRAP: begin
                t = r_v - wrap_step(r_step);
                if (t > PI_Q24) begin
                    r_v <= t;
                end
                r_step <= r_step + 3'd1;
            end
            S_JFIX: begin
                v      = (r_v > PI_Q24) ? r_v - TWO_PI_Q24 : r_v;
                ws     = r_neg ? -v : v;
                r_wneg <= ws < 0;
                r_mag  <= (ws < 0) ? 26'(-ws) : 26'(ws);
            end
            S_JMUL: begin
                prod = 53'(r_mag * DEG_SCALE) + 53'({r_dt, 19'b0});
                r_x  <= 49'(prod >> 20);
            end
            S_TSQ: begin
                d_pos = 33'(cur_pos[r_axis]) -
                        33'(signed'(r_row[TOOL_BASE + r_axis*POS_W +: POS_W]));
                m     = (d_pos < 0) ? 33'(-d_pos) : 33'(d_pos);
                if (r_axis == '0) begin
                    r_sum <= 66'(m * m);
                end else begin
                    r_sum <= r_sum + 66'(m * m);
                end
                r_axis <= r_axis + 2'd1;
                r_root <= '0;
                r_srem <= '0;
                r_sk   <= ROOT_TOP;
            end
            S_TSQRT: begin
                vq    = {r_sum, 16'b0} >> {r_sk, 1'b0};
                pair  = vq[1:0];
                srem  = {r_srem[42:0], pair};
                trial = 45'({r_root, 2'b01});
                if (srem >= trial) begin
                    r_srem <= srem - trial;
                    r_root <= {r_root[39:0], 1'b1};
                end else begin
                    r_srem <= srem;
                    r_root <= {r_root[39:0], 1'b0};
                end
                r_sk <= r_sk - 6'd1;
            end
            S_TMUL: begin
                tn     = 56'(r_root * TOOL_SCALE) + 56'({r_dt, 5'b0});
                r_x    <= 49'(tn >> 6);
                r_tool <= 1'b1;
            end
            S_DINIT: begin
                if ({7'b0, r_x[48:24]} >= r_dt) begin
                    r_q <= '1;
                end else begin
                    r_q   <= '0;
                    r_rem <= 32'(r_x >> 24);
                    r_bit <= 5'(SPEED_W - 1);
                end
            end
            S_DITER: begin
                dtrial = {r_rem, r_x[r_bit]};
                if (dtrial >= 33'(r_dt)) begin
                    r_rem <= 32'(dtrial - 33'(r_dt));
                    r_q   <= {r_q[SPEED_W-2:0], 1'b1};
                end else begin
                    r_rem <= 32'(dtrial);
                    r_q   <= {r_q[SPEED_W-2:0], 1'b0};
                end
                r_bit <= r_bit - 5'd1;
            end
            S_DSTORE: begin
                if (!r_tool) begin
                    if (r_wneg) begin
                        qs = (r_q > 24'd8388608) ? 24'd8388608 : r_q;
                        r_speed[r_j] <= -qs;
                    end else begin
                        r_speed[r_j] <= (r_q > 24'd8388607) ? 24'd8388607 : r_q;
                    end
                    r_j    <= r_j + 3'd1;
                    r_axis <= '0;
                end
            end
            S_DONE: begin
                if (!r_ov) begin
                    r_out.result_time_us <= r_cur.sample_time_us;
                    r_out.joint_speed_0  <= r_speed[0];
                    r_out.joint_speed_1  <= r_speed[1];
                    r_out.joint_speed_2  <= r_speed[2];
                    r_out.joint_speed_3  <= r_speed[3];
                    r_out.joint_speed_4  <= r_speed[4];
                    r_out.joint_speed_5  <= r_speed[5];
                    r_out.tool_speed     <= r_q;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HISTORY_DEPTH))
        else $error("stored count beyond ring depth");

    a_ref_not_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCHK) |-> (r_ref != r_slot))
        else $error("reference slot equals newest slot");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ov) |=> r_ov)
        else $error("finished result not loaded");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DITER) |-> !i_sample.ready)
        else $error("sample taken during divide");
endmodule
